### hdl/swcb_pkg.sv
// Shared types and constants for the sliding window chunk buffer.
// No dependencies; imported by sliding_window_chunk_buffer.
`default_nettype none

package swcb_pkg;

  // Window geometry (a power of two, so the slot index is the low seq bits)
  localparam int unsigned SLOTS    = 64;
  localparam int unsigned IdxW     = $clog2(SLOTS);
  localparam int unsigned CntW     = 12;
  localparam logic [31:0] SpanM1   = 32'(SLOTS - 1);

  // Action codes
  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActQuery  = 2'd1;
  localparam logic [1:0] ActMap    = 2'd2;
  localparam logic [1:0] ActCount  = 2'd3;

  // Status codes
  localparam logic [2:0] StStored   = 3'd0;
  localparam logic [2:0] StReplaced = 3'd1;
  localparam logic [2:0] StLate     = 3'd2;
  localparam logic [2:0] StHit      = 3'd3;
  localparam logic [2:0] StMiss     = 3'd4;
  localparam logic [2:0] StMapWord  = 3'd5;
  localparam logic [2:0] StCount    = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seq_num;
    logic [31:0] chunk_ref;
  } in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            found;
    logic [31:0]     found_ref;
    logic [31:0]     map_word;
    logic [CntW-1:0] filled_count;
    logic [31:0]     start_seq;
    logic [31:0]     newest_seq;
    logic            last;
  } out_t;

endpackage

`default_nettype wire

### hdl/sliding_window_chunk_buffer.sv
// Receive window of chunk slots: tag and handle in one synchronous memory,
// valid bits in flops. Depends on swcb_pkg.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_t)
//
// Insert and query: accept, then one slot read-modify-write
//   through the memory's single read port.
// Map and count: one slot read per cycle on that port while the output is not stalled.
// A stalled output pauses the walk at a word boundary and holds a lookup.
// Reset clears the valid bits at once; no clearing pass is needed.
`default_nettype none

module sliding_window_chunk_buffer
  import swcb_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output out_t out_data_o
);

  localparam logic [1:0] StateIdle   = 2'd0;
  localparam logic [1:0] StateLookup = 2'd1;
  localparam logic [1:0] StateWalk   = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [1:0]      act_q;
  logic [31:0]     seq_q;
  logic [31:0]     ref_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     word_q, word_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     start_q, start_d;
  logic [31:0]     head_q, head_d;
  logic [SLOTS-1:0] valid_q;

  logic [63:0]     mem [SLOTS];
  logic [63:0]     rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;

  logic            in_acc;
  logic            out_free;
  logic            res_vld;
  out_t            res;
  out_t            out_q;
  logic            out_valid_q;

  logic [31:0]     rd_tag, rd_handle;
  logic            present;
  logic            walk_last, word_end, walk_hold;
  logic            late;
  logic [IdxW-1:0] slot;

  assign in_stall_o = (state_q != StateIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign rd_tag    = rd_data_q[63:32];
  assign rd_handle = rd_data_q[31:0];
  assign slot      = seq_q[IdxW-1:0];
  assign late      = seq_q < start_q;
  assign present   = valid_q[idx_q] && (rd_tag >= start_q);
  assign walk_last = (idx_q == IdxW'(SLOTS - 1));
  assign word_end  = (idx_q[4:0] == 5'd31) || walk_last;

  // Main sequencer: lookup result, walk accumulation, window update
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    word_d    = word_q;
    count_d   = count_q;
    start_d   = start_q;
    head_d    = head_q;
    mem_we    = 1'b0;
    res_vld   = 1'b0;
    walk_hold = 1'b0;
    res       = '0;
    rd_addr   = idx_q;
    case (state_q)
      StateIdle: begin
        if (in_valid_i && (in_data_i.action == ActMap || in_data_i.action == ActCount)) begin
          rd_addr = '0;
        end else begin
          rd_addr = in_data_i.seq_num[IdxW-1:0];
        end
        if (in_acc) begin
          idx_d   = '0;
          word_d  = '0;
          count_d = '0;
          if (in_data_i.action == ActMap || in_data_i.action == ActCount) begin
            state_d = StateWalk;
          end else begin
            state_d = StateLookup;
          end
        end
      end
      StateLookup: begin
        rd_addr = slot;
        if (act_q == ActInsert) begin
          if (late) begin
            res.status = StLate;
          end else begin
            res.status = valid_q[slot] ? StReplaced : StStored;
            if (seq_q > head_q) begin
              head_d  = seq_q;
              start_d = (seq_q >= SpanM1) ? (seq_q - SpanM1) : '0;
            end
          end
        end else if (valid_q[slot] && rd_tag == seq_q) begin
          res.status    = StHit;
          res.found     = 1'b1;
          res.found_ref = rd_handle;
        end else begin
          res.status = StMiss;
        end
        res.last = 1'b1;
        if (out_free) begin
          res_vld = 1'b1;
          mem_we  = (act_q == ActInsert) && !late;
          state_d = StateIdle;
        end else begin
          head_d  = head_q;
          start_d = start_q;
        end
      end
      StateWalk: begin
        word_d  = word_q | (32'(present) << idx_q[4:0]);
        count_d = count_q + CntW'(present);
        if (act_q == ActMap) begin
          res.status   = StMapWord;
          res.map_word = word_d;
          res.last     = walk_last;
          walk_hold    = word_end && !out_free;
          res_vld      = word_end && out_free;
        end else begin
          res.status       = StCount;
          res.filled_count = count_d;
          res.last         = 1'b1;
          walk_hold        = walk_last && !out_free;
          res_vld          = walk_last && out_free;
        end
        if (walk_hold) begin
          word_d  = word_q;
          count_d = count_q;
          rd_addr = idx_q;
        end else begin
          // advance to the next slot; drop the finished word
          if (word_end && act_q == ActMap) begin
            word_d = '0;
          end
          if (walk_last) begin
            rd_addr = '0;
            state_d = StateIdle;
          end else begin
            rd_addr = idx_q + IdxW'(1);
            idx_d   = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
    res.start_seq  = start_d;
    res.newest_seq = head_d;
  end

  // Control registers and slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      start_q     <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      head_q  <= head_d;
      if (mem_we) begin
        valid_q[slot] <= 1'b1;
      end
      if (res_vld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, walk accumulators and output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= in_data_i.action;
      seq_q <= in_data_i.seq_num;
      ref_q <= in_data_i.chunk_ref;
    end
    idx_q   <= idx_d;
    word_q  <= word_d;
    count_q <= count_d;
    if (res_vld) begin
      out_q <= res;
    end
  end

  // Slot memory: tag and handle, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot] <= {seq_q, ref_q};
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled transaction");

  // Head never moves backward
  a_head_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q >= $past(head_q))
    else $error("head sequence decreased");

  // Window start trails the head by exactly SLOTS - 1, or sits at zero
  a_window_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q == '0) || (head_q - start_q == SpanM1))
    else $error("window start out of step with head");

  // The memory is written only while finishing an in-window insert
  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StateLookup && act_q == ActInsert && seq_q >= start_q))
    else $error("slot write outside an insert");

  // A count never exceeds the number of slots
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.filled_count <= CntW'(SLOTS)))
    else $error("filled count above slot count");

endmodule

`default_nettype wire
